// ----- hw/rtl/lmrq_pkg.sv -----
// ----------------------------------------------------------------------------
// lmrq_pkg: shared types and codes of the mutex request queue
// Event codes, status codes, counter limits and the per-cell control word.
// ----------------------------------------------------------------------------
package lmrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int STAMP_BITS_DEF  = 16;

  localparam int ID_W    = 4;
  localparam int FUNC_W  = 3;
  localparam int CNT_W   = 5;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_PEER_REQ = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEER_REP = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEER_REL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PEER_DONE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_OWN_REQ  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_OWN_REL  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_HEAD = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_TYPE = 3'd4;

  localparam logic [KIND_W-1:0] MC_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] MC_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] MC_RELEASE = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_OWN_ID  = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_NUM_PROC = 1'd1;

  localparam logic [CNT_W-1:0] REPLY_MAX = 5'd31;
  localparam logic [CNT_W-1:0] DONE_MAX  = 5'd16;
  localparam logic [CNT_W-1:0] NP_MIN    = 5'd2;

  localparam logic [ID_W-1:0]  OWN_ID_RST = 4'd1;
  localparam logic [CNT_W-1:0] NUM_PROC_RST = 5'd2;

  // per-cell command: insert in sorted place, or shift toward the head
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/lmrq_cell.sv -----
// ----------------------------------------------------------------------------
// lmrq_cell: one slot of the sorted request chain
// Holds one (id, stamp) pair; loads the new pair, its left or its right
// neighbor depending on the command and the neighbor compare flag.
// ----------------------------------------------------------------------------
module lmrq_cell #(
  parameter int STAMP_BITS = lmrq_pkg::STAMP_BITS_DEF
) (
  input  logic                      clk,
  input  lmrq_pkg::cell_ctl_t       ctl,
  input  logic                      valid,
  input  logic                      left_lt,
  input  logic [lmrq_pkg::ID_W-1:0] new_id,
  input  logic [STAMP_BITS-1:0]     new_stamp,
  input  logic [lmrq_pkg::ID_W-1:0] left_id,
  input  logic [STAMP_BITS-1:0]     left_stamp,
  input  logic [lmrq_pkg::ID_W-1:0] right_id,
  input  logic [STAMP_BITS-1:0]     right_stamp,
  output logic [lmrq_pkg::ID_W-1:0] id,
  output logic [STAMP_BITS-1:0]     stamp,
  output logic                      lt
);

  logic [lmrq_pkg::ID_W-1:0] id_r, id_nxt;
  logic [STAMP_BITS-1:0]     stamp_r, stamp_nxt;

  // new key sorts before this one; an empty slot counts as infinity
  assign lt = !valid || (new_stamp < stamp_r) ||
              ((new_stamp == stamp_r) && (new_id < id_r));

  always_comb begin
    id_nxt    = id_r;
    stamp_nxt = stamp_r;
    if (ctl.ins) begin
      if (left_lt) begin
        id_nxt    = left_id;
        stamp_nxt = left_stamp;
      end else if (lt) begin
        id_nxt    = new_id;
        stamp_nxt = new_stamp;
      end
    end else if (ctl.pop) begin
      id_nxt    = right_id;
      stamp_nxt = right_stamp;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    stamp_r <= stamp_nxt;
  end

  assign id    = id_r;
  assign stamp = stamp_r;

endmodule

// ----- hw/rtl/lmrq_chain.sv -----
// ----------------------------------------------------------------------------
// lmrq_chain: row of cells kept sorted by (stamp, id)
// Cell 0 always holds the head; the fill count marks the live cells.
// ----------------------------------------------------------------------------
module lmrq_chain #(
  parameter int QUEUE_DEPTH = lmrq_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = lmrq_pkg::STAMP_BITS_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  lmrq_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]             count,
  input  logic [lmrq_pkg::ID_W-1:0] new_id,
  input  logic [STAMP_BITS-1:0]     new_stamp,
  output logic [lmrq_pkg::ID_W-1:0] head_id
);

  logic [lmrq_pkg::ID_W-1:0] ids    [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0]     stamps [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    lts;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      l_lt;
    logic [lmrq_pkg::ID_W-1:0] l_id, r_id;
    logic [STAMP_BITS-1:0]     l_st, r_st;

    if (i == 0) begin : g_first
      assign l_lt = 1'b0;
      assign l_id = new_id;
      assign l_st = new_stamp;
    end else begin : g_mid
      assign l_lt = lts[i-1];
      assign l_id = ids[i-1];
      assign l_st = stamps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_id = ids[i];
      assign r_st = stamps[i];
    end else begin : g_inner
      assign r_id = ids[i+1];
      assign r_st = stamps[i+1];
    end

    lmrq_cell #(
      .STAMP_BITS(STAMP_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (count > CW'(i)),
      .left_lt    (l_lt),
      .new_id     (new_id),
      .new_stamp  (new_stamp),
      .left_id    (l_id),
      .left_stamp (l_st),
      .right_id   (r_id),
      .right_stamp(r_st),
      .id         (ids[i]),
      .stamp      (stamps[i]),
      .lt         (lts[i])
    );
  end

  assign head_id = ids[0];

endmodule

// ----- hw/rtl/lamport_mutex_request_queue.sv -----
// ----------------------------------------------------------------------------
// lamport_mutex_request_queue: one node of Lamport mutual exclusion
// Request queue held sorted in a chain of cells, plus reply/done counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_func, in_peer_id and in_stamp with start high;
//   the request is taken at the clock edge where start is high and busy is
//   low. busy then stays high for one cycle while the result is shown.
//   Result channel: out_valid pulses for exactly one cycle, in the cycle after
//   the request was taken, with all out_ fields valid in that cycle. The
//   receiver cannot stall; the result is gone after that cycle.
//   Sequencing: no new request is taken while a result is shown. The
//   request updates the cell chain (a sorted insert or a shift toward the
//   head, all cells in parallel); the result shows the head from cell 0.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 own
//   node id, 1 process count) at the clock edge; write only while idle.
//   Reset (rst_n low, synchronous): empties the queue, clears the reply and
//   done counters and the own-waiting flag, drops any pending result and
//   loads the register defaults. No clearing pass: the fill count alone
//   marks the live cells.
// ----------------------------------------------------------------------------
module lamport_mutex_request_queue #(
  parameter int QUEUE_DEPTH = lmrq_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = lmrq_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [lmrq_pkg::FUNC_W-1:0]  in_func,
  input  logic [lmrq_pkg::ID_W-1:0]    in_peer_id,
  input  logic [STAMP_BITS-1:0]        in_stamp,
  output logic                         out_valid,
  output logic                         out_send_reply,
  output logic [lmrq_pkg::ID_W-1:0]    out_reply_target,
  output logic [lmrq_pkg::KIND_W-1:0]  out_multicast_kind,
  output logic                         out_granted,
  output logic [lmrq_pkg::STAT_W-1:0]  out_status,
  output logic [lmrq_pkg::ID_W-1:0]    out_head_node,
  output logic [lmrq_pkg::CNT_W-1:0]   out_done_total,
  input  logic                         cfg_we,
  input  logic [lmrq_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [lmrq_pkg::CFG_D_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // configuration
  logic [lmrq_pkg::ID_W-1:0]  own_id_r;
  logic [lmrq_pkg::CNT_W-1:0] num_proc_r;

  // control state
  logic                       busy_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [lmrq_pkg::CNT_W-1:0] reply_r, reply_nxt;
  logic [lmrq_pkg::CNT_W-1:0] done_r, done_nxt;
  logic                       own_wait_r, own_wait_nxt;

  // per-request result fields captured at accept
  logic                        send_r, send_nxt;
  logic [lmrq_pkg::ID_W-1:0]   target_r, target_nxt;
  logic [lmrq_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [lmrq_pkg::STAT_W-1:0] stat_r, stat_nxt;

  logic                      accept;
  logic                      full, empty;
  lmrq_pkg::cell_ctl_t       ctl;
  logic [lmrq_pkg::ID_W-1:0] new_id;
  logic [lmrq_pkg::ID_W-1:0] head_id;
  logic [lmrq_pkg::CNT_W-1:0] need;

  assign accept = start && !busy_r;
  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign new_id = (in_func == lmrq_pkg::FUNC_OWN_REQ) ? own_id_r : in_peer_id;

  // decode the request: counters, queue command and the result fields
  always_comb begin
    count_nxt    = count_r;
    reply_nxt    = reply_r;
    done_nxt     = done_r;
    own_wait_nxt = own_wait_r;
    send_nxt     = 1'b0;
    target_nxt   = '0;
    kind_nxt     = lmrq_pkg::MC_NONE;
    stat_nxt     = lmrq_pkg::STAT_OK;
    ctl          = '0;
    case (in_func)
      lmrq_pkg::FUNC_PEER_REQ: begin
        if (full) begin
          stat_nxt = lmrq_pkg::STAT_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_nxt  = count_r + CW'(1);
          send_nxt   = 1'b1;
          target_nxt = in_peer_id;
        end
      end
      lmrq_pkg::FUNC_PEER_REP: begin
        if (reply_r < lmrq_pkg::REPLY_MAX) begin
          reply_nxt = reply_r + lmrq_pkg::CNT_W'(1);
        end
      end
      lmrq_pkg::FUNC_PEER_REL: begin
        if (empty) begin
          stat_nxt = lmrq_pkg::STAT_EMPTY;
        end else if (head_id != in_peer_id) begin
          stat_nxt = lmrq_pkg::STAT_NOT_HEAD;
        end else begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      lmrq_pkg::FUNC_PEER_DONE: begin
        if (done_r < lmrq_pkg::DONE_MAX) begin
          done_nxt = done_r + lmrq_pkg::CNT_W'(1);
        end
      end
      lmrq_pkg::FUNC_OWN_REQ: begin
        if (full) begin
          stat_nxt = lmrq_pkg::STAT_FULL;
        end else begin
          ctl.ins      = 1'b1;
          count_nxt    = count_r + CW'(1);
          reply_nxt    = '0;
          own_wait_nxt = 1'b1;
          kind_nxt     = lmrq_pkg::MC_REQUEST;
        end
      end
      lmrq_pkg::FUNC_OWN_REL: begin
        if (empty) begin
          stat_nxt = lmrq_pkg::STAT_EMPTY;
        end else if (head_id != own_id_r) begin
          stat_nxt = lmrq_pkg::STAT_NOT_HEAD;
        end else begin
          ctl.pop      = 1'b1;
          count_nxt    = count_r - CW'(1);
          own_wait_nxt = 1'b0;
          kind_nxt     = lmrq_pkg::MC_RELEASE;
        end
      end
      default: begin
        stat_nxt = lmrq_pkg::STAT_BAD_TYPE;
      end
    endcase
    // hold everything unless a request is taken
    if (!accept) begin
      ctl          = '0;
      count_nxt    = count_r;
      reply_nxt    = reply_r;
      done_nxt     = done_r;
      own_wait_nxt = own_wait_r;
    end
  end

  lmrq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (count_r),
    .new_id   (new_id),
    .new_stamp(in_stamp),
    .head_id  (head_id)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= lmrq_pkg::OWN_ID_RST;
      num_proc_r <= lmrq_pkg::NUM_PROC_RST;
      busy_r     <= 1'b0;
      count_r    <= '0;
      reply_r    <= '0;
      done_r     <= '0;
      own_wait_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          lmrq_pkg::CFG_OWN_ID:   own_id_r   <= cfg_wdata[lmrq_pkg::ID_W-1:0];
          lmrq_pkg::CFG_NUM_PROC: num_proc_r <= cfg_wdata;
          default: ;
        endcase
      end
      busy_r     <= accept;
      count_r    <= count_nxt;
      reply_r    <= reply_nxt;
      done_r     <= done_nxt;
      own_wait_r <= own_wait_nxt;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      send_r   <= send_nxt;
      target_r <= target_nxt;
      kind_r   <= kind_nxt;
      stat_r   <= stat_nxt;
    end
  end

  // grant threshold: process count minus two, floored at zero
  assign need = (num_proc_r >= lmrq_pkg::NP_MIN) ? (num_proc_r - lmrq_pkg::NP_MIN) : '0;

  assign busy               = busy_r;
  assign out_valid          = busy_r;
  assign out_send_reply     = send_r;
  assign out_reply_target   = target_r;
  assign out_multicast_kind = kind_r;
  assign out_status         = stat_r;
  assign out_head_node      = empty ? '0 : head_id;
  assign out_granted        = own_wait_r && !empty && (reply_r >= need) &&
                              (head_id == own_id_r);
  assign out_done_total     = done_r;

endmodule
